// File: rtl/core/ray_orientation_and_advance_defines.svh
// Assertion macros shared by the ray orientation and advance RTL.
// No dependencies; included by the modules that carry concurrent checks.
`ifndef RAY_ORIENTATION_AND_ADVANCE_DEFINES_SVH
`define RAY_ORIENTATION_AND_ADVANCE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ROA_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ROA_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/roa_pkg.sv
// Shared types, constants and helpers for the ray orientation and advance block.
// No dependencies; imported by every module of the block.
package roa_pkg;

  localparam int ANGLE_BITS_DEF   = 16;
  localparam int COORD_BITS_DEF   = 32;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int STEP_LIMIT = 24;
  localparam int CORDIC_W   = 52;   // vectoring inputs are 32-bit values times 2^16, plus growth
  localparam int ANG_Z_W    = 34;   // angle accumulator, 32-bit turn plus headroom
  localparam int MUL_W      = 34;
  localparam int THOU_IN_W  = 38;
  localparam int DIR_W      = 11;
  localparam int DIV_W      = 41;
  localparam int REM_W      = 10;
  localparam int OP_W       = 3;

  localparam int DIR_SCALE  = 1000;
  localparam int ROUND_HALF = DIR_SCALE / 2;
  localparam logic [31:0] GAIN_Q30 = 32'd652032874;

  localparam logic [31:0] ATAN_TURN [STEP_LIMIT] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic [OP_W-1:0] {
    OP_MOVE       = 3'd0,
    OP_TURN_YAW   = 3'd1,
    OP_TURN_PITCH = 3'd2,
    OP_SET_DIR    = 3'd3,
    OP_SET_START  = 3'd4
  } roa_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_APPLY,
    S_VY,
    S_VY_W,
    S_MH,
    S_ML,
    S_MS,
    S_VP,
    S_VP_W,
    S_RY,
    S_RY_W,
    S_RP,
    S_RP_W,
    S_PX,
    S_PY,
    S_PZ,
    S_MM,
    S_MD,
    S_MW,
    S_OUT
  } roa_state_t;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // Q2.30 value to signed thousandths, half away from zero, clamped to one.
  function automatic logic signed [DIR_W-1:0] to_thou(input logic signed [THOU_IN_W-1:0] v);
    logic signed [47:0] w;
    logic signed [47:0] p;
    logic [47:0] m;
    logic [18:0] q;
    w = 48'(v);
    p = (w <<< 10) - (w <<< 4) - (w <<< 3);
    m = p[47] ? 48'(-p) : 48'(p);
    q = 19'((m + 48'(1 << 29)) >> 30);
    if (q > 19'(DIR_SCALE)) begin
      q = 19'(DIR_SCALE);
    end
    to_thou = p[47] ? -DIR_W'(q) : DIR_W'(q);
  endfunction

endpackage

// File: rtl/core/roa_cordic.sv
// Shared CORDIC iteration unit: one micro-rotation per cycle, rotation or vectoring.
// Depends on roa_pkg for widths, the arctangent table and the control structs.
module roa_cordic import roa_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cordic_ctl_t                ctl,
  input  logic signed [CORDIC_W-1:0] x0,
  input  logic signed [CORDIC_W-1:0] y0,
  input  logic signed [ANG_Z_W-1:0]  z0,
  output unit_sts_t                  sts,
  output logic signed [CORDIC_W-1:0] x_out,
  output logic signed [CORDIC_W-1:0] y_out,
  output logic signed [ANG_Z_W-1:0]  z_out
);

  localparam int NUM_STEPS = (STEPS > STEP_LIMIT) ? STEP_LIMIT : STEPS;
  localparam int CNT_W     = $clog2(NUM_STEPS);

  logic signed [CORDIC_W-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [ANG_Z_W-1:0]  z_r, z_nxt, at;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r, done_r, vect_r, rot_pos, last;

  always_comb begin
    // vectoring drives y toward zero, rotation drives z toward zero
    rot_pos = vect_r ? y_r[CORDIC_W-1] : !z_r[ANG_Z_W-1];
    xs      = x_r >>> cnt_r;
    ys      = y_r >>> cnt_r;
    at      = ANG_Z_W'(ATAN_TURN[5'(cnt_r)]);
    x_nxt   = rot_pos ? x_r - ys : x_r + ys;
    y_nxt   = rot_pos ? y_r + xs : y_r - xs;
    z_nxt   = rot_pos ? z_r - at : z_r + at;
    last    = (cnt_r == CNT_W'(NUM_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      vect_r <= 1'b0;
    end else begin
      done_r <= busy_r && last;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        vect_r <= ctl.vectoring;
      end else if (busy_r) begin
        if (last) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x_r <= x0;
      y_r <= y0;
      z_r <= z0;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign sts   = '{busy: busy_r, done: done_r};
  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule

// File: rtl/core/roa_div.sv
// Divider by the thousandths scale: reciprocal multiplication, then one correction step.
// Depends on roa_pkg for widths, the divisor and the status struct.
module roa_div import roa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  output unit_sts_t        sts,
  output logic [DIV_W-1:0] quotient
);

  // floor(2^DIV_W / 1000): the estimate is the quotient or one below it
  localparam logic [31:0] RECIP = 32'((64'd1 << DIV_W) / DIR_SCALE);
  localparam int LO_W  = 20;
  localparam int HI_W  = DIV_W - LO_W;
  localparam int PRD_W = HI_W + 32;
  localparam int Q_W   = PRD_W + 1 - HI_W;

  localparam logic [1:0] PH_LO  = 2'd0;
  localparam logic [1:0] PH_HI  = 2'd1;
  localparam logic [1:0] PH_FIX = 2'd2;

  logic [DIV_W-1:0] num_r;
  logic [PRD_W-1:0] acc_r, prod;
  logic [PRD_W:0]   sum;
  logic [Q_W-1:0]   quo_r;
  logic [HI_W-1:0]  mul_in;
  logic [DIV_W+1:0] back;
  logic [REM_W:0]   rem;
  logic [1:0]       ph_r;
  logic             busy_r, done_r, last;

  always_comb begin
    // low part of the dividend first, high part second
    mul_in = (ph_r == PH_LO) ? HI_W'(num_r[LO_W-1:0]) : num_r[DIV_W-1:LO_W];
    prod   = PRD_W'(mul_in) * PRD_W'(RECIP);
    sum    = (PRD_W + 1)'(prod) + (PRD_W + 1)'(acc_r >> LO_W);
    back   = (DIV_W + 2)'(quo_r) * (DIV_W + 2)'(DIR_SCALE);
    rem    = (REM_W + 1)'((DIV_W + 2)'(num_r) - back);
    last   = (ph_r == PH_FIX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= PH_LO;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= PH_LO;
      end else if (busy_r) begin
        if (last) begin
          busy_r <= 1'b0;
        end else begin
          ph_r <= ph_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
    end else if (busy_r) begin
      case (ph_r)
        PH_LO:   acc_r <= prod;
        PH_HI:   quo_r <= Q_W'(sum >> HI_W);
        default: begin
          // remainder of one scale or more: bump the estimate
          if (rem >= (REM_W + 1)'(DIR_SCALE)) begin
            quo_r <= quo_r + Q_W'(1);
          end
        end
      endcase
    end
  end

  assign sts      = '{busy: busy_r, done: done_r};
  assign quotient = DIV_W'(quo_r);

endmodule

// File: rtl/core/roa_mul.sv
// Shared signed multiplier with a registered product.
// Depends on roa_pkg for the operand width.
module roa_mul import roa_pkg::*; (
  input  logic                       clk,
  input  logic signed [MUL_W-1:0]    a,
  input  logic signed [MUL_W-1:0]    b,
  output logic signed [2*MUL_W-1:0]  prod
);

  logic signed [2*MUL_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

// File: rtl/core/ray_orientation_and_advance.sv
// Top level of the ray orientation and advance block: sequencer and state.
// Depends on roa_pkg, roa_cordic, roa_div, roa_mul and the assertion macro header.
//
// Usage:
//   Input channel in_*: one transfer carries an operation in in_tuser and its
//   operands in in_tdata. Output channel out_*: one transfer per input item with
//   the start point, the direction in thousandths and both angles.
//   Each item runs through one shared CORDIC unit, one shared multiplier and a
//   divide-by-1000 unit (reciprocal multiply plus one correction) under a state
//   machine; in_tready is high only while the sequencer is idle. Turns, loads
//   and unknown codes run two CORDIC rotations; set direction first adds two
//   vectoring runs and the gain multiply, and move adds three divides, one per
//   axis, after the direction. The result sits in an output register: the next
//   item is accepted while it waits, and a stalled receiver only holds the
//   sequencer once the following result is ready. Reset (rst_n low, synchronous)
//   clears the point and both angles and empties the output register.
module ray_orientation_and_advance import roa_pkg::*; #(
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // amount[31:0], vec_x[63:32], vec_y[95:64], vec_z[127:96]
  input  logic [2:0]   in_tuser,   // operation[2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [167:0] out_tdata   // pos_x, pos_y, pos_z (32 each), dir_x, dir_y, dir_z
                                   // (11 each), yaw[144:129], pitch[160:145], zero pad
);

  `include "ray_orientation_and_advance_defines.svh"

  localparam int ASH = 32 - ANGLE_BITS;
  localparam logic [31:0] TURN_HALF = 32'd1 << (31 - ANGLE_BITS);
  localparam logic signed [63:0] COORD_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] COORD_MIN = -COORD_MAX - 64'sd1;

  roa_state_t state_r, state_nxt;

  logic [OP_W-1:0]              op_r;
  logic signed [31:0]           amt_r, vx_r, vy_r, vz_r;
  logic signed [COORD_BITS-1:0] pos_r [3];
  logic signed [DIR_W-1:0]      dir_r [3];
  logic [ANGLE_BITS-1:0]        yaw_r, pitch_r, angle_new;
  logic signed [MUL_W-1:0]      cy_r, sy_r, cp_r, sp_r;
  logic signed [CORDIC_W-1:0]   mag_r;
  logic                         zero_r, flip_r, neg_r;
  logic [1:0]                   axis_r;
  logic                         out_valid_r;
  logic [167:0]                 out_data_r;

  cordic_ctl_t                cordic_ctl;
  unit_sts_t                  cordic_sts, div_sts;
  logic signed [CORDIC_W-1:0] cx0, cy0, cx_out, cy_out;
  logic signed [ANG_Z_W-1:0]  cz0, cz_out;
  logic signed [CORDIC_W-1:0] vx_w, vy_w, vz_w;
  logic [31:0]                ang32, ang_fold, turn_round;
  logic                       rot_flip, vec_zero, vec_neg;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [2*MUL_W-1:0]  mul_p, mul_abs;
  logic                       div_start;
  logic [DIV_W-1:0]           div_dividend, div_q;
  logic signed [63:0]         q_step, pos_sum;
  logic signed [MUL_W-1:0]    rot_c, rot_s;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v > COORD_MAX) ? COORD_MAX : ((v < COORD_MIN) ? COORD_MIN : v);
    sat_coord = COORD_BITS'(r);
  endfunction

  roa_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cordic_ctl),
    .x0    (cx0),
    .y0    (cy0),
    .z0    (cz0),
    .sts   (cordic_sts),
    .x_out (cx_out),
    .y_out (cy_out),
    .z_out (cz_out)
  );

  roa_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_p)
  );

  roa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_APPLY;
      S_APPLY: state_nxt = (op_r == OP_SET_DIR) ? S_VY : S_RY;
      S_VY:    state_nxt = S_VY_W;
      S_VY_W:  if (cordic_sts.done) state_nxt = S_MH;
      S_MH:    state_nxt = S_ML;
      S_ML:    state_nxt = S_MS;
      S_MS:    state_nxt = S_VP;
      S_VP:    state_nxt = S_VP_W;
      S_VP_W:  if (cordic_sts.done) state_nxt = S_RY;
      S_RY:    state_nxt = S_RY_W;
      S_RY_W:  if (cordic_sts.done) state_nxt = S_RP;
      S_RP:    state_nxt = S_RP_W;
      S_RP_W:  if (cordic_sts.done) state_nxt = S_PX;
      S_PX:    state_nxt = S_PY;
      S_PY:    state_nxt = S_PZ;
      S_PZ:    state_nxt = (op_r == OP_MOVE) ? S_MM : S_OUT;
      S_MM:    state_nxt = S_MD;
      S_MD:    state_nxt = S_MW;
      S_MW: begin
        if (div_sts.done) begin
          state_nxt = (axis_r == 2'd2) ? S_OUT : S_MM;
        end
      end
      S_OUT:   if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Unit controls and operand selection
  always_comb begin
    vx_w     = CORDIC_W'(signed'({vx_r, 16'h0000}));
    vy_w     = CORDIC_W'(signed'({vy_r, 16'h0000}));
    vz_w     = CORDIC_W'(signed'({vz_r, 16'h0000}));
    ang32    = (state_r == S_RP) ? (32'(pitch_r) << ASH) : (32'(yaw_r) << ASH);
    rot_flip = ang32[31] ^ ang32[30];   // angle + quarter turn lands in the upper half
    ang_fold = rot_flip ? ang32 + 32'h8000_0000 : ang32;
    vec_neg  = vx_r[31];
    cordic_ctl = '{start: 1'b0, vectoring: 1'b0};
    cx0      = CORDIC_W'(signed'({1'b0, GAIN_Q30}));
    cy0      = '0;
    cz0      = ANG_Z_W'(signed'(ang_fold));
    vec_zero = 1'b0;
    mul_a    = cy_r;
    mul_b    = cp_r;
    div_start = 1'b0;
    mul_abs  = mul_p[2*MUL_W-1] ? -mul_p : mul_p;
    div_dividend = DIV_W'(mul_abs) + DIV_W'(ROUND_HALF);
    case (state_r)
      S_VY: begin
        cordic_ctl = '{start: 1'b1, vectoring: 1'b1};
        cx0      = vec_neg ? -vx_w : vx_w;
        cy0      = vec_neg ? -vy_w : vy_w;
        cz0      = vec_neg ? ANG_Z_W'(34'h0_8000_0000) : '0;
        vec_zero = (vx_r == '0) && (vy_r == '0);
      end
      S_VP: begin
        cordic_ctl = '{start: 1'b1, vectoring: 1'b1};
        cx0      = mag_r;
        cy0      = vz_w;
        cz0      = '0;
        vec_zero = (mag_r == '0) && (vz_r == '0);
      end
      S_RY, S_RP: begin
        cordic_ctl = '{start: 1'b1, vectoring: 1'b0};
      end
      S_MH: begin
        mul_a = MUL_W'(cx_out >>> 30);
        mul_b = MUL_W'(GAIN_Q30);
      end
      S_ML: begin
        mul_a = MUL_W'(cx_out[29:0]);
        mul_b = MUL_W'(GAIN_Q30);
      end
      S_PX: begin
        mul_a = cy_r;
        mul_b = cp_r;
      end
      S_PY: begin
        mul_a = sy_r;
        mul_b = cp_r;
      end
      S_MM: begin
        mul_a = MUL_W'(dir_r[axis_r]);
        mul_b = MUL_W'(amt_r);
      end
      S_MD: begin
        div_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    turn_round = cz_out[31:0] + TURN_HALF;
    angle_new  = zero_r ? '0 : turn_round[31 -: ANGLE_BITS];
    rot_c      = flip_r ? MUL_W'(-cx_out) : MUL_W'(cx_out);
    rot_s      = flip_r ? MUL_W'(-cy_out) : MUL_W'(cy_out);
    q_step     = signed'(64'(div_q));
    pos_sum    = 64'(pos_r[axis_r]) + (neg_r ? -q_step : q_step);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      yaw_r       <= '0;
      pitch_r     <= '0;
      pos_r[0]    <= '0;
      pos_r[1]    <= '0;
      pos_r[2]    <= '0;
      axis_r      <= '0;
    end else begin
      state_r <= state_nxt;
      // a new result loading in the same cycle keeps valid high
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_APPLY: begin
          case (op_r)
            OP_TURN_YAW:   yaw_r   <= yaw_r + amt_r[ANGLE_BITS-1:0];
            OP_TURN_PITCH: pitch_r <= pitch_r + amt_r[ANGLE_BITS-1:0];
            OP_SET_START: begin
              pos_r[0] <= sat_coord(64'(vx_r));
              pos_r[1] <= sat_coord(64'(vy_r));
              pos_r[2] <= sat_coord(64'(vz_r));
            end
            default: begin
            end
          endcase
        end
        S_VY_W:  if (cordic_sts.done) yaw_r <= angle_new;
        S_VP_W:  if (cordic_sts.done) pitch_r <= angle_new;
        S_PZ:    axis_r <= '0;
        S_MW: begin
          if (div_sts.done) begin
            pos_r[axis_r] <= sat_coord(pos_sum);
            axis_r        <= axis_r + 2'd1;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_r  <= in_tuser;
          amt_r <= in_tdata[31:0];
          vx_r  <= in_tdata[63:32];
          vy_r  <= in_tdata[95:64];
          vz_r  <= in_tdata[127:96];
        end
      end
      S_VY, S_VP: zero_r <= vec_zero;
      S_RY, S_RP: flip_r <= rot_flip;
      S_ML:   mag_r <= CORDIC_W'(mul_p);
      S_MS:   mag_r <= mag_r + CORDIC_W'(mul_p >>> 30);
      S_RY_W: begin
        if (cordic_sts.done) begin
          cy_r <= rot_c;
          sy_r <= rot_s;
        end
      end
      S_RP_W: begin
        if (cordic_sts.done) begin
          cp_r <= rot_c;
          sp_r <= rot_s;
        end
      end
      S_PY:   dir_r[0] <= to_thou(THOU_IN_W'(mul_p >>> 30));
      S_PZ: begin
        dir_r[1] <= to_thou(THOU_IN_W'(mul_p >>> 30));
        dir_r[2] <= to_thou(THOU_IN_W'(sp_r));
      end
      S_MD:   neg_r <= mul_p[2*MUL_W-1];
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_r <= {7'b0, 16'(pitch_r), 16'(yaw_r), dir_r[2], dir_r[1], dir_r[0],
                         32'(pos_r[2]), 32'(pos_r[1]), 32'(pos_r[0])};
        end
      end
      default: begin
      end
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ROA_ASSERT_NEXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !in_tready,
                   "second item taken before the first finished")
  `ROA_ASSERT_IMPL(a_cordic_free, clk, rst_n, cordic_ctl.start, !cordic_sts.busy,
                   "cordic restarted while iterating")
  `ROA_ASSERT_IMPL(a_div_move, clk, rst_n, div_start, op_r == OP_MOVE && !div_sts.busy,
                   "divider started outside a move")
  `ROA_ASSERT_IMPL(a_dir_range, clk, rst_n, state_r == S_OUT,
                   dir_r[0] <= 11'sd1000 && dir_r[0] >= -11'sd1000,
                   "direction component out of range")

endmodule
